[src/assert_macros.svh]
// Assertion helpers for the scheduler RTL.
// Each macro takes a label, a clock, an active-low reset and a property or condition.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CTS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("scheduler assertion failed");
`define CTS_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("scheduler forbidden condition seen");
`else
`define CTS_ASSERT(lbl, clk, rst_n, prop)
`define CTS_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

[src/cts_pkg.sv]
// ----------------------------------------------------------------------------
// cts_pkg: shared types and constants of the tick scheduler
// Queue entry layout, queue write commands, policy and register codes.
// ----------------------------------------------------------------------------
package cts_pkg;

	localparam int QUEUE_DEPTH_DEF  = 16;
	localparam int COUNTER_BITS_DEF = 32;

	localparam int REM_W  = 8;
	localparam int SEQ_W  = 16;
	localparam int OUT_W  = 160;

	// register indexes on the configuration port
	localparam logic [1:0] REG_POLICY  = 2'd0;
	localparam logic [1:0] REG_QUANTUM = 2'd1;
	localparam logic [1:0] REG_SWITCH  = 2'd2;

	// scheduling policies
	localparam logic [1:0] POL_FCFS = 2'd0;
	localparam logic [1:0] POL_RR   = 2'd1;
	localparam logic [1:0] POL_SJF  = 2'd2;
	localparam logic [1:0] POL_SRTF = 2'd3;

	typedef enum logic [1:0] {
		QOP_NONE,
		QOP_APPEND,
		QOP_REMOVE
	} cts_qop_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [SEQ_W-1:0] seq;
	} cts_entry_t;

	// write command broadcast to every cell of the queue
	typedef struct packed {
		cts_qop_t   op;
		cts_entry_t data;
	} cts_wr_t;

endpackage

[src/cpu_tick_scheduler.sv]
// A tick passes through S_EXEC, then S_DISP when a dispatch request is made, then S_ARR
// and S_OUT, where the result is loaded, plus up to two waits for the head search to settle
// after the queue changed (before execution and dispatch).
// One tick at a time: the next is accepted once the result is loaded, so search waits and
// any stall on the full output register hold off the next tick.
// Reset (arst_n low, asynchronous) clears fill, job state, counters and registers.
// ----------------------------------------------------------------------------
// cpu_tick_scheduler: tick-driven CPU scheduler (FCFS, RR, SJF, SRTF)
// Each input beat is one tick; each tick yields one result beat.
// Queue entry contents are not cleared by reset; only written entries are read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpu_tick_scheduler #(
	parameter int QUEUE_DEPTH  = cts_pkg::QUEUE_DEPTH_DEF,
	parameter int COUNTER_BITS = cts_pkg::COUNTER_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration
	input  logic                      cfg_wr_en,
	input  logic [1:0]                cfg_index,
	input  logic [7:0]                cfg_data,
	// tick input
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [7:0]                s_axis_tdata,  // burst_length
	input  logic [0:0]                s_axis_tuser,  // arrival_valid
	// result output
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// busy_res, running_id, job_finished, job_preempted, dispatched, dispatched_id,
	// arrival_refused, assigned_id, queue_count, idle_ticks, busy_ticks,
	// switch_ticks, zero pad
	output logic [cts_pkg::OUT_W-1:0] m_axis_tdata
);
	import cts_pkg::*;

	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam logic [FW-1:0] DEPTH_F = FW'(QUEUE_DEPTH);
	localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;
	localparam logic [COUNTER_BITS-1:0] CNT_ONE = COUNTER_BITS'(1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DISP,
		S_ARR,
		S_OUT
	} state_t;

	state_t                  state_q;
	logic [1:0]              policy_q;
	logic [7:0]              quantum_q;
	logic [7:0]              switch_q;

	logic                    arr_q;
	logic [7:0]              burst_q;

	logic [FW-1:0]           fill_q;
	logic [FW-1:0]           settle_q;
	logic [SEQ_W-1:0]        next_seq_q;
	logic                    has_cur_q;
	logic                    waiting_q;
	logic [SEQ_W-1:0]        cur_seq_q;
	logic [REM_W-1:0]        cur_total_q;
	logic [REM_W-1:0]        cur_done_q;
	logic [7:0]              delay_q;
	logic [COUNTER_BITS-1:0] idle_q;
	logic [COUNTER_BITS-1:0] busy_q;
	logic [COUNTER_BITS-1:0] sw_q;

	logic                    r_busy_q;
	logic                    r_fin_q;
	logic                    r_pre_q;
	logic                    r_disp_q;
	logic [SEQ_W-1:0]        r_disp_id_q;
	logic                    r_ref_q;
	logic [SEQ_W-1:0]        r_asg_q;

	logic                    out_valid_q;
	logic [OUT_W-1:0]        out_data_q;

	cts_wr_t                 q_wr;
	logic [IW-1:0]           q_pos;
	cts_entry_t              q_oldest;
	cts_entry_t              q_short;
	logic [IW-1:0]           q_short_pos;

	cts_entry_t              head;
	logic [IW-1:0]           head_pos;
	logic                    head_ok;
	logic                    running;
	logic [REM_W-1:0]        done_n;
	logic [REM_W-1:0]        rem_n;
	logic                    fin_c;
	logic                    stop_c;
	logic                    pre_c;
	logic [SEQ_W-1:0]        seq_n;
	logic                    refuse_c;
	logic                    out_load;

	cts_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.FW          (FW),
		.IW          (IW)
	) u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr           (q_wr),
		.fill         (fill_q),
		.rm_pos       (q_pos),
		.oldest       (q_oldest),
		.shortest     (q_short),
		.shortest_pos (q_short_pos)
	);

	// head selection by policy
	always_comb begin
		if (policy_q == POL_SJF || policy_q == POL_SRTF) begin
			head     = q_short;
			head_pos = q_short_pos;
		end else begin
			head     = q_oldest;
			head_pos = '0;
		end
	end

	assign head_ok = settle_q == '0;
	assign running = has_cur_q && !waiting_q;
	assign done_n  = cur_done_q + 8'd1;
	assign rem_n   = cur_total_q - done_n;
	assign fin_c   = done_n >= cur_total_q;
	assign seq_n   = next_seq_q + 16'd1;

	// stop decision for the executing job
	always_comb begin
		stop_c = fin_c;
		if (policy_q == POL_RR && done_n >= quantum_q) begin
			stop_c = 1'b1;
		end
		if (policy_q == POL_SRTF && fill_q != '0 && q_short.rem < rem_n) begin
			stop_c = 1'b1;
		end
		pre_c = stop_c && !fin_c && (policy_q == POL_RR || policy_q == POL_SRTF);
	end

	assign refuse_c = (fill_q + FW'(running)) >= DEPTH_F;

	// queue write command for this cycle
	always_comb begin
		q_wr  = '{op: QOP_NONE, data: '0};
		q_pos = head_pos;
		unique case (state_q)
			S_EXEC: begin
				if (head_ok && running && stop_c && pre_c) begin
					q_wr = '{op: QOP_APPEND, data: '{rem: rem_n, seq: seq_n}};
				end
			end
			S_DISP: begin
				if (head_ok && fill_q != '0 && delay_q == 8'd0) begin
					q_wr.op = QOP_REMOVE;
				end
			end
			S_ARR: begin
				if (arr_q && !refuse_c) begin
					q_wr = '{op: QOP_APPEND, data: '{rem: burst_q, seq: seq_n}};
				end
			end
			default: begin
			end
		endcase
	end

	assign out_load      = state_q == S_OUT && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = state_q == S_IDLE;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q  <= POL_FCFS;
			quantum_q <= 8'd5;
			switch_q  <= 8'd0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_POLICY:  policy_q  <= cfg_data[1:0];
				REG_QUANTUM: quantum_q <= cfg_data;
				REG_SWITCH:  switch_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// search settle timer: restarts whenever the queue changes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= '0;
		end else if (q_wr.op != QOP_NONE) begin
			settle_q <= DEPTH_F;
		end else if (settle_q != '0) begin
			settle_q <= settle_q - FW'(1);
		end
	end

	// tick sequencer and job state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			arr_q       <= 1'b0;
			burst_q     <= '0;
			fill_q      <= '0;
			next_seq_q  <= '0;
			has_cur_q   <= 1'b0;
			waiting_q   <= 1'b1;
			cur_seq_q   <= '0;
			cur_total_q <= '0;
			cur_done_q  <= '0;
			delay_q     <= '0;
			idle_q      <= '0;
			busy_q      <= '0;
			sw_q        <= '0;
			r_busy_q    <= 1'b0;
			r_fin_q     <= 1'b0;
			r_pre_q     <= 1'b0;
			r_disp_q    <= 1'b0;
			r_disp_id_q <= '0;
			r_ref_q     <= 1'b0;
			r_asg_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						arr_q       <= s_axis_tuser[0];
						burst_q     <= s_axis_tdata;
						r_busy_q    <= 1'b0;
						r_fin_q     <= 1'b0;
						r_pre_q     <= 1'b0;
						r_disp_q    <= 1'b0;
						r_disp_id_q <= '0;
						r_ref_q     <= 1'b0;
						r_asg_q     <= '0;
						state_q     <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (!running) begin
						state_q <= S_DISP;
					end else if (head_ok) begin
						r_busy_q   <= 1'b1;
						cur_done_q <= done_n;
						busy_q     <= (busy_q == CNT_MAX) ? busy_q : busy_q + CNT_ONE;
						r_fin_q    <= stop_c && fin_c;
						r_pre_q    <= pre_c;
						if (pre_c) begin
							next_seq_q  <= seq_n;
							cur_total_q <= done_n;
							fill_q      <= fill_q + FW'(1);
						end
						state_q <= stop_c ? S_DISP : S_ARR;
					end
				end
				S_DISP: begin
					if (head_ok) begin
						if (fill_q == '0) begin
							idle_q    <= (idle_q == CNT_MAX) ? idle_q : idle_q + CNT_ONE;
							waiting_q <= 1'b1;
						end else if (delay_q != 8'd0) begin
							delay_q   <= delay_q - 8'd1;
							sw_q      <= (sw_q == CNT_MAX) ? sw_q : sw_q + CNT_ONE;
							waiting_q <= 1'b1;
						end else begin
							cur_seq_q   <= head.seq;
							cur_total_q <= head.rem;
							cur_done_q  <= '0;
							has_cur_q   <= 1'b1;
							waiting_q   <= 1'b0;
							delay_q     <= switch_q;
							fill_q      <= fill_q - FW'(1);
							r_disp_q    <= 1'b1;
							r_disp_id_q <= head.seq;
						end
						state_q <= S_ARR;
					end
				end
				S_ARR: begin
					if (arr_q) begin
						if (refuse_c) begin
							r_ref_q <= 1'b1;
						end else begin
							next_seq_q <= seq_n;
							r_asg_q    <= seq_n;
							fill_q     <= fill_q + FW'(1);
						end
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {6'd0, 32'(sw_q), 32'(busy_q), 32'(idle_q), 5'(fill_q),
				r_asg_q, r_ref_q, r_disp_id_q, r_disp_q, r_pre_q, r_fin_q,
				cur_seq_q, r_busy_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// checks
	`CTS_NEVER(a_fill_bound, clk, arst_n, fill_q > DEPTH_F)
	`CTS_ASSERT(a_remove_settled, clk, arst_n, (q_wr.op == QOP_REMOVE) |-> (settle_q == '0))
	`CTS_ASSERT(a_accept_exec, clk, arst_n, (s_axis_tvalid && s_axis_tready) |=> (state_q == S_EXEC))
	`CTS_NEVER(a_remove_empty, clk, arst_n, q_wr.op == QOP_REMOVE && fill_q == '0)

endmodule

[src/cts_cell.sv]
// ----------------------------------------------------------------------------
// cts_cell: one slot of the ready queue
// Holds one entry, shifts from its upper neighbour on removal and passes the
// running best (shortest, oldest on ties) candidate on to the next cell.
// ----------------------------------------------------------------------------
module cts_cell #(
	parameter int IDX = 0,
	parameter int FW  = 5,
	parameter int IW  = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cts_pkg::cts_wr_t     wr,
	input  logic [FW-1:0]        fill,
	input  logic [IW-1:0]        rm_pos,
	input  cts_pkg::cts_entry_t  nb_entry,
	output cts_pkg::cts_entry_t  entry,
	input  logic                 best_in_found,
	input  cts_pkg::cts_entry_t  best_in,
	input  logic [IW-1:0]        best_in_pos,
	output logic                 best_found,
	output cts_pkg::cts_entry_t  best,
	output logic [IW-1:0]        best_pos
);
	import cts_pkg::*;

	localparam logic [FW-1:0] IDX_F  = FW'(IDX);
	localparam logic [FW-1:0] IDX1_F = FW'(IDX + 1);
	localparam logic [IW-1:0] IDX_I  = IW'(IDX);

	cts_entry_t         entry_q;
	logic               best_found_q;
	cts_entry_t         best_q;
	logic [IW-1:0]      best_pos_q;
	logic               live;
	logic               take;

	// entry storage: append at the fill mark, close the gap on removal
	always_ff @(posedge clk) begin
		if (wr.op == QOP_APPEND && fill == IDX_F) begin
			entry_q <= wr.data;
		end else if (wr.op == QOP_REMOVE && IDX_I >= rm_pos && IDX1_F < fill) begin
			entry_q <= nb_entry;
		end
	end

	// strict less keeps the older entry on ties
	assign live = IDX_F < fill;
	assign take = live && (!best_in_found || entry_q.rem < best_in.rem);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_found_q <= 1'b0;
		end else begin
			best_found_q <= best_in_found | live;
		end
	end

	always_ff @(posedge clk) begin
		best_q     <= take ? entry_q : best_in;
		best_pos_q <= take ? IDX_I : best_in_pos;
	end

	assign entry      = entry_q;
	assign best_found = best_found_q;
	assign best       = best_q;
	assign best_pos   = best_pos_q;

endmodule

[src/cts_queue.sv]
// ----------------------------------------------------------------------------
// cts_queue: ready queue as a row of cells
// Entry 0 is the oldest; the best candidate ripples one cell per cycle and
// leaves the last cell once it has passed through every cell since the queue last changed.
// ----------------------------------------------------------------------------
module cts_queue #(
	parameter int QUEUE_DEPTH = cts_pkg::QUEUE_DEPTH_DEF,
	parameter int FW          = $clog2(QUEUE_DEPTH + 1),
	parameter int IW          = $clog2(QUEUE_DEPTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cts_pkg::cts_wr_t     wr,
	input  logic [FW-1:0]        fill,
	input  logic [IW-1:0]        rm_pos,
	output cts_pkg::cts_entry_t  oldest,
	output cts_pkg::cts_entry_t  shortest,
	output logic [IW-1:0]        shortest_pos
);
	import cts_pkg::*;

	cts_entry_t         ent   [QUEUE_DEPTH+1];
	logic               bfnd  [QUEUE_DEPTH+1];
	cts_entry_t         bent  [QUEUE_DEPTH+1];
	logic [IW-1:0]      bpos  [QUEUE_DEPTH+1];

	// chain ends
	assign ent[QUEUE_DEPTH] = '0;
	assign bfnd[0]          = 1'b0;
	assign bent[0]          = '0;
	assign bpos[0]          = '0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		cts_cell #(
			.IDX (i),
			.FW  (FW),
			.IW  (IW)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.wr            (wr),
			.fill          (fill),
			.rm_pos        (rm_pos),
			.nb_entry      (ent[i+1]),
			.entry         (ent[i]),
			.best_in_found (bfnd[i]),
			.best_in       (bent[i]),
			.best_in_pos   (bpos[i]),
			.best_found    (bfnd[i+1]),
			.best          (bent[i+1]),
			.best_pos      (bpos[i+1])
		);
	end

	assign oldest       = ent[0];
	assign shortest     = bent[QUEUE_DEPTH];
	assign shortest_pos = bpos[QUEUE_DEPTH];

endmodule
